>>> sv/bmpdec_pkg.sv
// shared types, codes and helpers of the bmp pixel decoder
`timescale 1ns / 1ps
package bmpdec_pkg;

  localparam int unsigned HDR_LEN        = 54;
  localparam int unsigned PAL_DEPTH      = 256;
  localparam int unsigned PAL_AW         = 8;
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // header byte positions
  localparam int unsigned POS_SIZE   = 2;
  localparam int unsigned POS_OFF    = 10;
  localparam int unsigned POS_INFO   = 14;
  localparam int unsigned POS_WIDTH  = 18;
  localparam int unsigned POS_HEIGHT = 22;
  localparam int unsigned POS_BPP    = 28;
  localparam int unsigned POS_COMP   = 30;

  localparam logic [7:0]  SIG_B    = 8'h42;
  localparam logic [7:0]  SIG_M    = 8'h4d;
  localparam logic [31:0] INFO_LEN = 32'd40;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_UNSUP   = 2'd2;

  localparam logic [1:0] MODE_1  = 2'd0;
  localparam logic [1:0] MODE_4  = 2'd1;
  localparam logic [1:0] MODE_8  = 2'd2;
  localparam logic [1:0] MODE_24 = 2'd3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        is_pixel;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [23:0] pixel_index;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [1:0]  status;
    logic        done_res;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  sig0;
    logic [7:0]  sig1;
    logic [31:0] size;
    logic [31:0] off;
    logic [31:0] info;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] bpp;
    logic [31:0] comp;
  } hdr_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] line;
    logic [23:0] row_base;
  } chk_res_t;

  function automatic logic [PAL_AW-1:0] pal_idx(input logic [7:0] b, input logic [1:0] mode,
                                                input logic [2:0] k);
    logic [PAL_AW-1:0] r;
    begin
      r = b;
      case (mode)
        MODE_4:  r = (k == 3'd0) ? {4'h0, b[7:4]} : {4'h0, b[3:0]};
        MODE_1:  r = {7'h0, b[3'd7 - k]};
        default: r = b;
      endcase
      return r;
    end
  endfunction

endpackage

>>> sv/bmp_to_rgb_pixel_decoder_core.sv
// top level of the bmp to rgb pixel decoder
`timescale 1ns / 1ps
// Takes a BMP file one byte per transfer on the in_ channel (in_valid, in_stall,
// in_data) and returns pixel results and one final status result per file on
// the out_ channel. Write the file length on cfg_wr_en/cfg_wr_data before the
// first byte of each file, while the block is idle.
// Header and palette bytes are taken without a stall. The 54th header byte
// starts a header check (line size, then a 32-step serial multiply of line size
// by height); in_stall is high during it. A pixel byte is taken and then yields
// its pixels one after another (up to eight for 1 bit per pixel), paced by the
// palette memory read port; a 24-bit pixel byte yields at most one. A status
// result follows the pixels of the last byte. The first result of a byte is
// loaded into the out_ register from the S_PIX or S_STAT state after its transfer.
// When out_stall is high the output register holds its result and the block
// stops taking bytes once it has another result to give.
// Reset (rst_n low, synchronous) clears the control state, sets the file length
// to zero and waits for the first header byte; palette contents are not cleared.
module bmp_to_rgb_pixel_decoder_core
  import bmpdec_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW  = CW + 4;
  localparam int unsigned LBW = $clog2(MAX_WIDTH * 3 + 4) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_PIX  = 2'd2;
  localparam logic [1:0] S_STAT = 2'd3;

  localparam logic [1:0] PH_HDR   = 2'd0;
  localparam logic [1:0] PH_PAL   = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_DRAIN = 2'd3;

  logic [1:0]     state_r, state_nxt;
  logic [1:0]     phase_r, phase_nxt;
  logic [31:0]    flen_r, flen_nxt;
  logic [31:0]    bpos_r, bpos_nxt;
  hdr_t           hdr_r, hdr_nxt;
  logic [1:0]     mode_r, mode_nxt;
  logic [LBW-1:0] line_r, line_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [LBW-1:0] rbc_r, rbc_nxt;
  logic [23:0]    rbase_r, rbase_nxt;
  logic [15:0]    part_r, part_nxt;
  logic [1:0]     cbp_r, cbp_nxt;
  logic [7:0]     byte_r, byte_nxt;
  logic [3:0]     npix_r, npix_nxt;
  logic [2:0]     k_r, k_nxt;
  logic [23:0]    base_r, base_nxt;
  logic [23:0]    pix24_r, pix24_nxt;
  logic           spend_r, spend_nxt;
  logic [1:0]     st_r, st_nxt;
  logic           dims_r, dims_nxt;
  logic           last_r, last_nxt;
  logic           flhit_r, flhit_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_r, out_nxt;

  logic              in_fire, out_free, restart, fin, start_chk, pix_fire;
  logic [1:0]        st;
  logic              dims;
  logic [31:0]       cur, pk;
  logic [3:0]        npix;
  logic [CW-1:0]     wcw;
  logic [RW-1:0]     rem;
  logic              pal_we;
  logic [PAL_AW-1:0] pal_waddr, pal_raddr;
  logic [23:0]       pal_wdata, pal_rdata, pix_rgb;
  logic              chk_done;
  chk_res_t          chk_res;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cur      = bpos_r;
  assign pk       = cur - 32'(HDR_LEN);
  assign wcw      = hdr_r.width[CW-1:0];
  assign rem      = RW'(wcw) - RW'(col_r);
  assign pix_fire = (state_r == S_PIX) && out_free;
  assign pix_rgb  = (mode_r == MODE_24) ? pix24_r : pal_rdata;

  always_comb begin
    state_nxt = state_r;   phase_nxt = phase_r;   flen_nxt  = flen_r;
    bpos_nxt  = bpos_r;    hdr_nxt   = hdr_r;     mode_nxt  = mode_r;
    line_nxt  = line_r;    col_nxt   = col_r;     rbc_nxt   = rbc_r;
    rbase_nxt = rbase_r;   part_nxt  = part_r;    cbp_nxt   = cbp_r;
    byte_nxt  = byte_r;    npix_nxt  = npix_r;    k_nxt     = k_r;
    base_nxt  = base_r;    pix24_nxt = pix24_r;   spend_nxt = spend_r;
    st_nxt    = st_r;      dims_nxt  = dims_r;    last_nxt  = last_r;
    flhit_nxt = flhit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt   = out_r;
    restart   = 1'b0;
    fin       = 1'b0;
    st        = ST_INVALID;
    dims      = 1'b0;
    start_chk = 1'b0;
    npix      = 4'd0;
    pal_we    = 1'b0;
    pal_waddr = pk[PAL_AW+1:2];
    pal_wdata = {in_data.byte_value, part_r};

    if (cfg_wr_en) begin
      flen_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (phase_r == PH_DRAIN) begin
            restart = in_data.last_byte;
          end else begin
            bpos_nxt = cur + 32'd1;
            if (phase_r == PH_HDR) begin
              if (cur == 32'd0 && flen_r < 32'(HDR_LEN)) begin
                fin = 1'b1;
              end else begin
                if (cur == 32'd0) hdr_nxt.sig0 = in_data.byte_value;
                if (cur == 32'd1) hdr_nxt.sig1 = in_data.byte_value;
                if (cur >= 32'(POS_SIZE) && cur < 32'(POS_SIZE + 4))
                  hdr_nxt.size = {in_data.byte_value, hdr_r.size[31:8]};
                if (cur >= 32'(POS_OFF) && cur < 32'(POS_OFF + 4))
                  hdr_nxt.off = {in_data.byte_value, hdr_r.off[31:8]};
                if (cur >= 32'(POS_INFO) && cur < 32'(POS_INFO + 4))
                  hdr_nxt.info = {in_data.byte_value, hdr_r.info[31:8]};
                if (cur >= 32'(POS_WIDTH) && cur < 32'(POS_WIDTH + 4))
                  hdr_nxt.width = {in_data.byte_value, hdr_r.width[31:8]};
                if (cur >= 32'(POS_HEIGHT) && cur < 32'(POS_HEIGHT + 4))
                  hdr_nxt.height = {in_data.byte_value, hdr_r.height[31:8]};
                if (cur >= 32'(POS_BPP) && cur < 32'(POS_BPP + 2))
                  hdr_nxt.bpp = {in_data.byte_value, hdr_r.bpp[15:8]};
                if (cur >= 32'(POS_COMP) && cur < 32'(POS_COMP + 4))
                  hdr_nxt.comp = {in_data.byte_value, hdr_r.comp[31:8]};
                if (cur == 32'(HDR_LEN - 1)) begin
                  start_chk = 1'b1;
                  state_nxt = S_CHK;
                  last_nxt  = in_data.last_byte;
                  flhit_nxt = (cur == flen_r - 32'd1);
                end
              end
            end else if (phase_r == PH_PAL) begin
              if (pk[31:PAL_AW+2] == '0) begin
                case (pk[1:0])
                  2'd0:    part_nxt = {8'h00, in_data.byte_value};
                  2'd1:    part_nxt = {in_data.byte_value, part_r[7:0]};
                  2'd2:    pal_we = 1'b1;
                  default: pal_we = 1'b0;
                endcase
              end
              if (cur + 32'd1 == hdr_r.off) begin
                phase_nxt = PH_DATA;
                part_nxt  = 16'h0000;
              end
            end else begin
              // pixel data byte
              if (col_r < wcw) begin
                case (mode_r)
                  MODE_8:  npix = 4'd1;
                  MODE_4:  npix = (rem >= RW'(2)) ? 4'd2 : 4'd1;
                  MODE_1:  npix = (rem >= RW'(8)) ? 4'd8 : rem[3:0];
                  default: begin
                    case (cbp_r)
                      2'd0: begin
                        part_nxt = {8'h00, in_data.byte_value};
                        cbp_nxt  = 2'd1;
                      end
                      2'd1: begin
                        part_nxt = {in_data.byte_value, part_r[7:0]};
                        cbp_nxt  = 2'd2;
                      end
                      default: begin
                        pix24_nxt = {in_data.byte_value, part_r};
                        cbp_nxt   = 2'd0;
                        npix      = 4'd1;
                      end
                    endcase
                  end
                endcase
              end
              base_nxt = rbase_r + 24'(col_r);
              col_nxt  = col_r + CW'(npix);
              if ({1'b0, rbc_r} + (LBW + 1)'(1) >= (LBW + 1)'(line_r)) begin
                rbc_nxt   = '0;
                col_nxt   = '0;
                cbp_nxt   = 2'd0;
                rbase_nxt = rbase_r - hdr_r.width[23:0];
              end else begin
                rbc_nxt = rbc_r + LBW'(1);
              end
            end
            if (!start_chk) begin
              if (!fin && phase_nxt != PH_HDR && cur == flen_r - 32'd1) begin
                fin  = 1'b1;
                st   = ST_OK;
                dims = 1'b1;
              end
              if (!fin && in_data.last_byte) begin
                fin = 1'b1;
                st  = ST_INVALID;
              end
            end
            byte_nxt  = in_data.byte_value;
            k_nxt     = 3'd0;
            npix_nxt  = npix;
            spend_nxt = fin;
            st_nxt    = st;
            dims_nxt  = dims;
            if (npix != 4'd0) begin
              state_nxt = S_PIX;
            end else if (fin) begin
              state_nxt = S_STAT;
            end
            if (fin) begin
              phase_nxt = PH_DRAIN;
              restart   = in_data.last_byte;
            end
          end
        end
      end
      S_CHK: begin
        if (chk_done) begin
          if (chk_res.status != ST_OK) begin
            fin = 1'b1;
            st  = chk_res.status;
          end else begin
            rbase_nxt = chk_res.row_base;
            line_nxt  = chk_res.line[LBW-1:0];
            phase_nxt = (hdr_r.off == 32'(HDR_LEN)) ? PH_DATA : PH_PAL;
            case (hdr_r.bpp[4:0])
              5'd1:    mode_nxt = MODE_1;
              5'd4:    mode_nxt = MODE_4;
              5'd8:    mode_nxt = MODE_8;
              default: mode_nxt = MODE_24;
            endcase
            if (flhit_r) begin
              fin  = 1'b1;
              st   = ST_OK;
              dims = 1'b1;
            end else if (last_r) begin
              fin = 1'b1;
            end
          end
          st_nxt   = st;
          dims_nxt = dims;
          if (fin) begin
            phase_nxt = PH_DRAIN;
            restart   = last_r;
            state_nxt = S_STAT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_PIX: begin
        if (pix_fire) begin
          out_valid_nxt        = 1'b1;
          out_nxt.is_pixel     = 1'b1;
          out_nxt.red          = pix_rgb[23:16];
          out_nxt.green        = pix_rgb[15:8];
          out_nxt.blue         = pix_rgb[7:0];
          out_nxt.pixel_index  = base_r + 24'(k_r);
          out_nxt.image_width  = hdr_r.width[12:0];
          out_nxt.image_height = hdr_r.height[12:0];
          out_nxt.status       = ST_OK;
          out_nxt.done_res     = 1'b0;
          k_nxt = k_r + 3'd1;
          if ({1'b0, k_r} + 4'd1 == npix_r) begin
            state_nxt = spend_r ? S_STAT : S_IDLE;
          end
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.is_pixel     = 1'b0;
          out_nxt.red          = 8'h00;
          out_nxt.green        = 8'h00;
          out_nxt.blue         = 8'h00;
          out_nxt.pixel_index  = 24'h0;
          out_nxt.image_width  = dims_r ? hdr_r.width[12:0] : 13'h0;
          out_nxt.image_height = dims_r ? hdr_r.height[12:0] : 13'h0;
          out_nxt.status       = st_r;
          out_nxt.done_res     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (restart) begin
      bpos_nxt  = '0;
      phase_nxt = PH_HDR;
      col_nxt   = '0;
      rbc_nxt   = '0;
      rbase_nxt = '0;
      part_nxt  = '0;
      cbp_nxt   = 2'd0;
    end
  end

  assign pal_raddr = pal_idx(byte_nxt, mode_r, k_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_HDR;
      flen_r      <= '0;
      bpos_r      <= '0;
      col_r       <= '0;
      rbc_r       <= '0;
      rbase_r     <= '0;
      part_r      <= '0;
      cbp_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      flen_r      <= flen_nxt;
      bpos_r      <= bpos_nxt;
      col_r       <= col_nxt;
      rbc_r       <= rbc_nxt;
      rbase_r     <= rbase_nxt;
      part_r      <= part_nxt;
      cbp_r       <= cbp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r   <= hdr_nxt;
    mode_r  <= mode_nxt;
    line_r  <= line_nxt;
    byte_r  <= byte_nxt;
    npix_r  <= npix_nxt;
    k_r     <= k_nxt;
    base_r  <= base_nxt;
    pix24_r <= pix24_nxt;
    spend_r <= spend_nxt;
    st_r    <= st_nxt;
    dims_r  <= dims_nxt;
    last_r  <= last_nxt;
    flhit_r <= flhit_nxt;
    out_r   <= out_nxt;
  end

  bmpdec_pal_mem u_pal (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  bmpdec_hdr_chk #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start_chk),
    .hdr         (hdr_nxt),
    .file_length (flen_r),
    .done        (chk_done),
    .res         (chk_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_pix_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PIX) |-> (npix_r != 4'd0) && ({1'b0, k_r} < npix_r))
    else $error("pixel sequencer out of range");

  a_chk_state: assert property (@(posedge clk) disable iff (!rst_n)
    chk_done |-> (state_r == S_CHK))
    else $error("header check finished outside check state");

  a_pal_write: assert property (@(posedge clk) disable iff (!rst_n)
    pal_we |-> (phase_r == PH_PAL) && in_fire)
    else $error("palette write outside palette phase");

  a_stat_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STAT) && out_free |=> out_valid && out_data.done_res && !out_data.is_pixel)
    else $error("status transfer not loaded");

endmodule

>>> sv/bmpdec_pal_mem.sv
// palette memory, one write and one registered read port
`timescale 1ns / 1ps
module bmpdec_pal_mem
  import bmpdec_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [PAL_AW-1:0] waddr,
  input  logic [23:0]       wdata,
  input  logic [PAL_AW-1:0] raddr,
  output logic [23:0]       rdata
);

  logic [23:0] mem [PAL_DEPTH];
  logic [23:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/bmpdec_hdr_chk.sv
// header check with a serial line-size times height multiplier
`timescale 1ns / 1ps
module bmpdec_hdr_chk
  import bmpdec_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  hdr_t        hdr,
  input  logic [31:0] file_length,
  output logic        done,
  output chk_res_t    res
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_LINE = 3'd1;
  localparam logic [2:0] C_SER  = 3'd2;
  localparam logic [2:0] C_FIN  = 3'd3;

  logic [2:0]  state_r, state_nxt;
  logic [47:0] prod_r;
  logic [23:0] rowb_r;
  logic [44:0] line_r;
  logic [31:0] acc_r;
  logic        ovf_r;
  logic [31:0] hsh_r;
  logic [4:0]  cnt_r;

  logic [47:0] sum;
  logic [44:0] line_c;
  logic [33:0] step;
  logic [33:0] need4;
  logic [1:0]  st;

  assign sum    = prod_r + 48'd31;
  assign line_c = {sum[47:5], 2'b00};
  assign step   = {1'b0, acc_r, 1'b0} + {2'b00, (hsh_r[31] ? line_r[31:0] : 32'd0)};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE:  if (start) state_nxt = C_LINE;
      C_LINE:  state_nxt = C_SER;
      C_SER:   if (cnt_r == 5'd31) state_nxt = C_FIN;
      C_FIN:   state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == C_IDLE && start) begin
      prod_r <= hdr.width * hdr.bpp;
      rowb_r <= (hdr.height[23:0] - 24'd1) * hdr.width[23:0];
    end
    if (state_r == C_LINE) begin
      line_r <= line_c;
      acc_r  <= '0;
      ovf_r  <= (|line_c[44:32]) && (hdr.height != 32'd0);
      hsh_r  <= hdr.height;
      cnt_r  <= '0;
    end
    if (state_r == C_SER) begin
      acc_r <= step[31:0];
      if (|step[33:32]) begin
        ovf_r <= 1'b1;
      end
      hsh_r <= {hsh_r[30:0], 1'b0};
      cnt_r <= cnt_r + 5'd1;
    end
  end

  always_comb begin
    case (hdr.bpp)
      16'd1:   need4 = 34'd8;
      16'd4:   need4 = 34'd64;
      16'd8:   need4 = 34'd1024;
      default: need4 = 34'd0;
    endcase
    if (hdr.sig0 != SIG_B || hdr.sig1 != SIG_M || hdr.comp != 32'd0 || hdr.info != INFO_LEN) begin
      st = ST_UNSUP;
    end else if (ovf_r || hdr.size != file_length || hdr.size < hdr.off ||
                 (hdr.size - hdr.off) != acc_r || hdr.off < 32'(HDR_LEN) ||
                 {2'b00, hdr.off - 32'(HDR_LEN)} < need4) begin
      st = ST_INVALID;
    end else if (hdr.width > 32'(MAX_WIDTH) || hdr.height > 32'(MAX_HEIGHT)) begin
      st = ST_UNSUP;
    end else if (hdr.bpp != 16'd1 && hdr.bpp != 16'd4 && hdr.bpp != 16'd8 &&
                 hdr.bpp != 16'd24) begin
      st = ST_UNSUP;
    end else begin
      st = ST_OK;
    end
  end

  assign done         = (state_r == C_FIN);
  assign res.status   = st;
  assign res.line     = line_r[31:0];
  assign res.row_base = (hdr.height != 32'd0) ? rowb_r : 24'd0;

endmodule
